>>> rtl/tccs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types, constants and the microcode program of the text console
// with cursor and scrolling.
// ----------------------------------------------------------------------------
package tccs_pkg;

    // Geometry of the cell store
    localparam int MaxCols   = 128;
    localparam int MaxRows   = 32;
    localparam int CellCount = MaxCols * MaxRows;
    localparam int AddrW     = $clog2(CellCount);
    localparam int PtrW      = AddrW + 1;
    localparam int ColW      = $clog2(MaxCols) + 1;
    localparam int RowW      = $clog2(MaxRows) + 1;

    // Character and color codes
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [7:0]  SPACE_CODE   = 8'd32;
    localparam logic [7:0]  RESET_COLOR  = 8'd7;
    localparam logic [15:0] RESET_CELL   = {RESET_COLOR, SPACE_CODE};

    // Configuration register reset values and indexes
    localparam logic [7:0] RESET_COLS = 8'd80;
    localparam logic [5:0] RESET_ROWS = 6'd25;
    localparam logic [1:0] REG_COLS   = 2'd0;
    localparam logic [1:0] REG_ROWS   = 2'd1;
    localparam logic [1:0] REG_COLOR  = 2'd2;

    // Item opcodes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Microprogram step addresses
    typedef enum logic [4:0] {
        S_CLR   = 5'd0,
        S_IDLE  = 5'd1,
        S_DISP  = 5'd2,
        S_PUT0  = 5'd3,
        S_PUT1  = 5'd4,
        S_PUT2  = 5'd5,
        S_NL    = 5'd6,
        S_NLCHK = 5'd7,
        S_SC0   = 5'd8,
        S_SC1   = 5'd9,
        S_SC2   = 5'd10,
        S_SC3   = 5'd11,
        S_BL0   = 5'd12,
        S_BL1   = 5'd13,
        S_RD0   = 5'd14,
        S_RD1   = 5'd15,
        S_FIN   = 5'd16
    } t_step;

    // Branch conditions
    typedef enum logic [3:0] {
        C_NEVER    = 4'd0,
        C_ALWAYS   = 4'd1,
        C_IN_ACC   = 4'd2,
        C_IS_READ  = 4'd3,
        C_IS_NL    = 4'd4,
        C_COL_LT   = 4'd5,
        C_ROW_LT   = 4'd6,
        C_CLR_END  = 4'd7,
        C_COPY_END = 4'd8,
        C_ALL_END  = 4'd9,
        C_OUT_FREE = 4'd10
    } t_cond;

    typedef enum logic [1:0] {
        RD_NONE   = 2'd0,
        RD_IDX    = 2'd1,
        RD_SCROLL = 2'd2
    } t_rdsel;

    typedef enum logic [2:0] {
        WR_NONE  = 3'd0,
        WR_RESET = 3'd1,
        WR_CHAR  = 3'd2,
        WR_COPY  = 3'd3,
        WR_BLANK = 3'd4
    } t_wrsel;

    typedef enum logic [1:0] {
        PTR_KEEP = 2'd0,
        PTR_ZERO = 2'd1,
        PTR_INC  = 2'd2
    } t_ptrop;

    typedef enum logic [2:0] {
        CUR_KEEP    = 3'd0,
        CUR_CLAMP   = 3'd1,
        CUR_COLINC  = 3'd2,
        CUR_NEWROW  = 3'd3,
        CUR_LASTROW = 3'd4
    } t_curop;

    typedef enum logic [1:0] {
        ENT_KEEP = 2'd0,
        ENT_ZERO = 2'd1,
        ENT_MEM  = 2'd2
    } t_entop;

    // One control word
    typedef struct packed {
        t_cond  cond;
        t_step  target;
        logic   hold;
        logic   in_ready;
        t_rdsel rd;
        t_wrsel wr;
        t_ptrop ptr;
        t_curop cur;
        t_entop ent;
        logic   scr_set;
        logic   load_out;
    } t_ctl;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_acc;
        logic is_read;
        logic is_nl;
        logic col_lt;
        logic row_lt;
        logic clr_end;
        logic copy_end;
        logic all_end;
        logic out_free;
    } t_flags;

    // Microcode ROM: a branch is taken when cond holds; otherwise the step
    // either holds (hold set) or falls through to the next address.
    function automatic t_ctl ucode(input t_step step);
        t_ctl w;
        w.cond     = C_NEVER;
        w.target   = S_IDLE;
        w.hold     = 1'b0;
        w.in_ready = 1'b0;
        w.rd       = RD_NONE;
        w.wr       = WR_NONE;
        w.ptr      = PTR_KEEP;
        w.cur      = CUR_KEEP;
        w.ent      = ENT_KEEP;
        w.scr_set  = 1'b0;
        w.load_out = 1'b0;
        unique case (step)
            S_CLR: begin
                w.cond = C_CLR_END; w.target = S_IDLE; w.hold = 1'b1;
                w.wr = WR_RESET; w.ptr = PTR_INC;
            end
            S_IDLE: begin
                w.cond = C_IN_ACC; w.target = S_DISP; w.hold = 1'b1;
                w.in_ready = 1'b1;
            end
            S_DISP: begin
                w.cond = C_IS_READ; w.target = S_RD0;
            end
            S_PUT0: begin
                w.cond = C_IS_NL; w.target = S_NL;
                w.cur = CUR_CLAMP; w.ent = ENT_ZERO;
            end
            S_PUT1: begin
                w.wr = WR_CHAR; w.cur = CUR_COLINC;
            end
            S_PUT2: begin
                w.cond = C_COL_LT; w.target = S_FIN;
            end
            S_NL: begin
                w.cur = CUR_NEWROW;
            end
            S_NLCHK: begin
                w.cond = C_ROW_LT; w.target = S_FIN;
            end
            S_SC0: begin
                w.ptr = PTR_ZERO; w.cur = CUR_LASTROW; w.scr_set = 1'b1;
            end
            S_SC1: begin
                w.cond = C_COPY_END; w.target = S_BL0;
            end
            S_SC2: begin
                w.rd = RD_SCROLL;
            end
            S_SC3: begin
                w.cond = C_ALWAYS; w.target = S_SC1;
                w.wr = WR_COPY; w.ptr = PTR_INC;
            end
            S_BL0: begin
                w.cond = C_ALL_END; w.target = S_FIN;
            end
            S_BL1: begin
                w.cond = C_ALWAYS; w.target = S_BL0;
                w.wr = WR_BLANK; w.ptr = PTR_INC;
            end
            S_RD0: begin
                w.rd = RD_IDX; w.ent = ENT_ZERO;
            end
            S_RD1: begin
                w.cond = C_ALWAYS; w.target = S_FIN; w.ent = ENT_MEM;
            end
            S_FIN: begin
                w.cond = C_OUT_FREE; w.target = S_IDLE; w.hold = 1'b1;
                w.load_out = 1'b1;
            end
            default: begin
                w.cond = C_ALWAYS; w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

>>> rtl/tccs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_if
// Valid/ready channels of the text console: command items in, result
// items out.
// ----------------------------------------------------------------------------
interface tccs_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  char_code;
    logic [11:0] cell_index;

    modport source (output valid, output opcode, output char_code,
                    output cell_index, input ready);
    modport sink   (input valid, input opcode, input char_code,
                    input cell_index, output ready);
endinterface

interface tccs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_entry;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;

    modport source (output valid, output cell_entry, output cursor_row,
                    output cursor_col, output scrolled, input ready);
    modport sink   (input valid, input cell_entry, input cursor_row,
                    input cursor_col, input scrolled, output ready);
endinterface
`default_nettype wire

>>> rtl/tccs_useq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tccs_useq
// Microcode sequencer: step counter, control ROM and conditional branch.
// ----------------------------------------------------------------------------
module tccs_useq (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  tccs_pkg::t_flags      i_flags,
    output tccs_pkg::t_ctl        o_ctl,
    output logic                  o_taken
);

    tccs_pkg::t_step r_upc;
    tccs_pkg::t_step n_upc;
    tccs_pkg::t_ctl  ctl;
    logic            taken;

    // Control word lookup
    always_comb begin
        ctl = tccs_pkg::ucode(r_upc);
    end

    // Branch condition select
    always_comb begin
        unique case (ctl.cond)
            tccs_pkg::C_NEVER:    taken = 1'b0;
            tccs_pkg::C_ALWAYS:   taken = 1'b1;
            tccs_pkg::C_IN_ACC:   taken = i_flags.in_acc;
            tccs_pkg::C_IS_READ:  taken = i_flags.is_read;
            tccs_pkg::C_IS_NL:    taken = i_flags.is_nl;
            tccs_pkg::C_COL_LT:   taken = i_flags.col_lt;
            tccs_pkg::C_ROW_LT:   taken = i_flags.row_lt;
            tccs_pkg::C_CLR_END:  taken = i_flags.clr_end;
            tccs_pkg::C_COPY_END: taken = i_flags.copy_end;
            tccs_pkg::C_ALL_END:  taken = i_flags.all_end;
            tccs_pkg::C_OUT_FREE: taken = i_flags.out_free;
            default:              taken = 1'b0;
        endcase
    end

    // Next step: branch, hold or fall through
    always_comb begin
        priority if (taken) begin
            n_upc = ctl.target;
        end else if (ctl.hold) begin
            n_upc = r_upc;
        end else begin
            n_upc = tccs_pkg::t_step'(r_upc + 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= tccs_pkg::S_CLR;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl   = ctl;
    assign o_taken = taken;

endmodule
`default_nettype wire

>>> rtl/text_console_cursor_scroll_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top
// Text console cell store with cursor, line wrap and scroll-up.
//
// Command items arrive on i_in (valid/ready). A put (opcode 0) writes the
// character in the current color at the cursor and advances it; code 10 is
// a newline. A read (opcode 1) returns one cell by linear index. Every item
// produces one result item on o_out with the cursor and a scroll flag.
// Geometry and color are set through the APB port; the user must write them
// only while the block is idle, since the block itself does not enforce it.
// After reset a clearing pass writes a space in color 7 to all 4096 cells,
// one per cycle; no item is taken until the pass is done. A scroll copies
// each cell below the top row up one row and then blanks the last row in
// the current color, one cell at a time as the microcode program steps
// through the memory.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted, and a stalled receiver holds
// the sequencer at its final step until the register is taken.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    tccs_in_if.sink      i_in,
    tccs_out_if.source   o_out,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [3:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = tccs_pkg::AddrW;
    localparam int PW = tccs_pkg::PtrW;
    localparam int CW = tccs_pkg::ColW;
    localparam int RW = tccs_pkg::RowW;

    // Configuration registers
    logic [7:0] r_cfg_cols;
    logic [5:0] r_cfg_rows;
    logic [7:0] r_cfg_color;

    // Latched item
    logic        r_op;
    logic [7:0]  r_ch;
    logic [11:0] r_idx;

    // Cursor, sweep pointer, result scratch
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [PW-1:0] r_ptr;
    logic [15:0]   r_entry;
    logic          r_scr;

    // Output register
    logic        r_ov;
    logic [15:0] r_o_entry;
    logic [4:0]  r_o_row;
    logic [6:0]  r_o_col;
    logic        r_o_scr;

    // Cell memory
    logic [15:0] r_mem [tccs_pkg::CellCount];
    logic [15:0] r_rdata;

    tccs_pkg::t_ctl   ctl;
    tccs_pkg::t_flags flags;
    logic             taken;

    logic [CW-1:0] cols_eff;
    logic [RW-1:0] rows_eff;
    logic [PW-1:0] copy_end;
    logic [PW-1:0] all_end;
    logic [PW-1:0] char_addr;
    logic [PW-1:0] scroll_src;
    logic          in_acc;
    logic          cfg_wr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    // Effective geometry after range clamps
    always_comb begin
        priority if (r_cfg_cols == 8'd0) begin
            cols_eff = CW'(1);
        end else if (r_cfg_cols > 8'(tccs_pkg::MaxCols)) begin
            cols_eff = CW'(tccs_pkg::MaxCols);
        end else begin
            cols_eff = CW'(r_cfg_cols);
        end
        priority if (r_cfg_rows < 6'd2) begin
            rows_eff = RW'(2);
        end else if (r_cfg_rows > 6'(tccs_pkg::MaxRows)) begin
            rows_eff = RW'(tccs_pkg::MaxRows);
        end else begin
            rows_eff = RW'(r_cfg_rows);
        end
    end

    // Address arithmetic, operands widened to pointer width first
    assign copy_end   = PW'(rows_eff - RW'(1)) * PW'(cols_eff);
    assign all_end    = PW'(rows_eff) * PW'(cols_eff);
    assign char_addr  = PW'(r_row) * PW'(cols_eff) + PW'(r_col);
    assign scroll_src = r_ptr + PW'(cols_eff);

    // Sequencer
    assign in_acc = i_in.valid && i_in.ready;

    always_comb begin
        flags.in_acc   = in_acc;
        flags.is_read  = (r_op == tccs_pkg::OP_READ);
        flags.is_nl    = (r_ch == tccs_pkg::NEWLINE_CODE);
        flags.col_lt   = (r_col < cols_eff);
        flags.row_lt   = (r_row < rows_eff);
        flags.clr_end  = (r_ptr == PW'(tccs_pkg::CellCount - 1));
        flags.copy_end = (r_ptr == copy_end);
        flags.all_end  = (r_ptr == all_end);
        flags.out_free = !r_ov || o_out.ready;
    end

    tccs_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl),
        .o_taken (taken)
    );

    assign i_in.ready = ctl.in_ready;

    // Memory port selection
    always_comb begin
        rd_en   = (ctl.rd != tccs_pkg::RD_NONE);
        rd_addr = (ctl.rd == tccs_pkg::RD_SCROLL) ? scroll_src[AW-1:0] : r_idx[AW-1:0];
        wr_en   = (ctl.wr != tccs_pkg::WR_NONE);
        wr_addr = r_ptr[AW-1:0];
        unique case (ctl.wr)
            tccs_pkg::WR_RESET: wr_data = tccs_pkg::RESET_CELL;
            tccs_pkg::WR_CHAR: begin
                wr_data = {r_cfg_color, r_ch};
                wr_addr = char_addr[AW-1:0];
            end
            tccs_pkg::WR_COPY:  wr_data = r_rdata;
            tccs_pkg::WR_BLANK: wr_data = {r_cfg_color, tccs_pkg::SPACE_CODE};
            default:            wr_data = r_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Item latch
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_in.opcode;
            r_ch  <= i_in.char_code;
            r_idx <= i_in.cell_index;
        end
    end

    // Sweep pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            unique case (ctl.ptr)
                tccs_pkg::PTR_ZERO: r_ptr <= '0;
                tccs_pkg::PTR_INC:  r_ptr <= r_ptr + PW'(1);
                default:            r_ptr <= r_ptr;
            endcase
        end
    end

    // Cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            unique case (ctl.cur)
                tccs_pkg::CUR_CLAMP: begin
                    if (r_row >= rows_eff) r_row <= rows_eff - RW'(1);
                    if (r_col >= cols_eff) r_col <= cols_eff - CW'(1);
                end
                tccs_pkg::CUR_COLINC: r_col <= r_col + CW'(1);
                tccs_pkg::CUR_NEWROW: begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end
                tccs_pkg::CUR_LASTROW: r_row <= rows_eff - RW'(1);
                default: begin
                    r_row <= r_row;
                    r_col <= r_col;
                end
            endcase
        end
    end

    // Result scratch
    always_ff @(posedge i_clk) begin
        unique case (ctl.ent)
            tccs_pkg::ENT_ZERO: begin
                r_entry <= '0;
                r_scr   <= 1'b0;
            end
            tccs_pkg::ENT_MEM: r_entry <= r_rdata;
            default:           r_entry <= r_entry;
        endcase
        if (ctl.scr_set) begin
            r_scr <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ctl.load_out && taken) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load_out && taken) begin
            r_o_entry <= r_entry;
            r_o_row   <= r_row[4:0];
            r_o_col   <= r_col[6:0];
            r_o_scr   <= r_scr;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.cell_entry = r_o_entry;
    assign o_out.cursor_row = r_o_row;
    assign o_out.cursor_col = r_o_col;
    assign o_out.scrolled   = r_o_scr;

    // APB configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols  <= tccs_pkg::RESET_COLS;
            r_cfg_rows  <= tccs_pkg::RESET_ROWS;
            r_cfg_color <= tccs_pkg::RESET_COLOR;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                tccs_pkg::REG_COLS:  r_cfg_cols  <= pwdata[7:0];
                tccs_pkg::REG_ROWS:  r_cfg_rows  <= pwdata[5:0];
                tccs_pkg::REG_COLOR: r_cfg_color <= pwdata[7:0];
                default: begin
                    r_cfg_cols <= r_cfg_cols;
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tccs_pkg::REG_COLS:  prdata = {24'd0, r_cfg_cols};
            tccs_pkg::REG_ROWS:  prdata = {26'd0, r_cfg_rows};
            tccs_pkg::REG_COLOR: prdata = {24'd0, r_cfg_color};
            default:             prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

>>> dv/tb_text_console_cursor_scroll_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll_top
// Self-checking bench for the text console cell store with cursor and scroll.
//
// Items go in on the command channel and each returns one result item that is
// checked, field by field, against an in-bench model of the cell store, the
// cursor and the register set. A short directed table covers reset contents,
// character extremes, line wrap, newline scroll, out-of-range geometry and a
// cursor left outside a shrunk screen; random phases follow, each with its
// own geometry, color and pacing of the two channels. Registers are written
// over the APB port only while the console is idle, and read back.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll_top;

    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int REPORT_MAX    = 10;

    // One result item as the console reports it
    typedef struct packed {
        logic [15:0] entry;
        logic [4:0]  row;
        logic [6:0]  col;
        logic        scrolled;
    } t_console_result;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef enum logic [1:0] {
        PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH
    } t_pace;

    // One line of the directed table
    typedef struct packed {
        t_row_kind       kind;
        logic            op;
        logic [7:0]      ch;
        logic [11:0]     idx;
        logic [1:0]      reg_sel;
        logic [7:0]      reg_val;
        logic            typed;
        t_console_result want;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tccs_in_if  in_if ();
    tccs_out_if out_if ();

    text_console_cursor_scroll_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model of the console: cell store, cursor and registers
    logic [15:0]  screen [tccs_pkg::CellCount];
    int unsigned  cur_row;
    int unsigned  cur_col;
    logic [7:0]   cfg_cols;
    logic [5:0]   cfg_rows;
    logic [7:0]   cfg_color;

    t_console_result pending_results [$];
    t_directed_row   directed_rows [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int cycle_count = 0;
    int n_put, n_newline, n_read, n_scroll, n_reg_writes;

    t_console_result got_result;
    t_console_result head_result;

    // Effective geometry: out-of-range register values are clamped
    function automatic int unsigned eff_cols();
        if (cfg_cols < 1) return 1;
        if (cfg_cols > tccs_pkg::MaxCols) return tccs_pkg::MaxCols;
        return cfg_cols;
    endfunction

    function automatic int unsigned eff_rows();
        if (cfg_rows < 2) return 2;
        if (cfg_rows > tccs_pkg::MaxRows) return tccs_pkg::MaxRows;
        return cfg_rows;
    endfunction

    // Next row; past the bottom the screen moves up and the last row blanks
    function automatic bit advance_row(input int unsigned cols, input int unsigned rows);
        int unsigned r;
        int unsigned c;
        cur_row++;
        if (cur_row < rows) return 1'b0;
        for (r = 0; r + 1 < rows; r++)
            for (c = 0; c < cols; c++)
                screen[r * cols + c] = screen[(r + 1) * cols + c];
        for (c = 0; c < cols; c++)
            screen[(rows - 1) * cols + c] = {cfg_color, tccs_pkg::SPACE_CODE};
        cur_row = rows - 1;
        return 1'b1;
    endfunction

    // Result of one command item, updating the model state
    function automatic t_console_result console_predict(input logic op,
                                                        input logic [7:0] ch,
                                                        input logic [11:0] idx);
        t_console_result res;
        int unsigned     cols;
        int unsigned     rows;
        bit              scr;
        res = '0;
        scr = 1'b0;
        if (op == tccs_pkg::OP_READ) begin
            if (idx < tccs_pkg::CellCount) res.entry = screen[idx];
        end else begin
            cols = eff_cols();
            rows = eff_rows();
            // cursor may sit outside a geometry that just shrank
            if (cur_row >= rows) cur_row = rows - 1;
            if (cur_col >= cols) cur_col = cols - 1;
            if (ch == tccs_pkg::NEWLINE_CODE) begin
                cur_col = 0;
                scr = advance_row(cols, rows);
            end else begin
                screen[cur_row * cols + cur_col] = {cfg_color, ch};
                cur_col++;
                if (cur_col >= cols) begin
                    cur_col = 0;
                    scr = advance_row(cols, rows);
                end
            end
        end
        res.row      = 5'(cur_row);
        res.col      = 7'(cur_col);
        res.scrolled = scr;
        return res;
    endfunction

    task automatic log_mismatch(input string text);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) $display("MISMATCH: %s", text);
    endtask

    task automatic set_pacing(input t_pace mode);
        case (mode)
            PACE_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_IDLE:  begin send_idle_pct = 68; recv_stall_pct = 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default:         begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
    endtask

    // Offer one item, wait for it to be taken, queue what it should return
    task automatic send_item(input logic op, input logic [7:0] ch, input logic [11:0] idx,
                             input logic typed, input t_console_result want);
        t_console_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.opcode     <= op;
        in_if.char_code  <= ch;
        in_if.cell_index <= idx;
        @(posedge i_clk);
        while ((in_if.valid && in_if.ready) !== 1'b1) @(posedge i_clk);
        pred = console_predict(op, ch, idx);
        pending_results.push_back(typed ? want : pred);
        if (op == tccs_pkg::OP_READ) n_read++;
        else if (ch == tccs_pkg::NEWLINE_CODE) n_newline++;
        else n_put++;
        if (pred.scrolled) n_scroll++;
    endtask

    // Register write while idle, then read back over APB
    task automatic reg_write(input logic [1:0] sel, input logic [7:0] val);
        logic [31:0] mask;
        logic [31:0] rd;
        case (sel)
            tccs_pkg::REG_ROWS: mask = 32'h3F;
            default:            mask = 32'hFF;
        endcase
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        // write: setup then access, bits above the register are noise
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= ($urandom() & ~mask) | (32'(val) & mask);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            tccs_pkg::REG_COLS: cfg_cols  = val;
            tccs_pkg::REG_ROWS: cfg_rows  = val[5:0];
            default:            cfg_color = val;
        endcase
        n_reg_writes++;
        // read back
        @(posedge i_clk);
        psel  <= 1'b1;
        paddr <= {sel, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((rd & mask) !== (32'(val) & mask))
            log_mismatch($sformatf("register %0d read back %h, expected %h",
                                   sel, rd & mask, 32'(val) & mask));
    endtask

    // Directed table builders
    task automatic add_item(input logic op, input logic [7:0] ch, input logic [11:0] idx);
        t_directed_row line;
        line = '0;
        line.kind = ROW_ITEM;
        line.op   = op;
        line.ch   = ch;
        line.idx  = idx;
        directed_rows.push_back(line);
    endtask

    task automatic add_typed(input logic op, input logic [7:0] ch, input logic [11:0] idx,
                             input logic [15:0] entry, input logic [4:0] row,
                             input logic [6:0] col, input logic scr);
        t_directed_row line;
        line = '0;
        line.kind  = ROW_ITEM;
        line.op    = op;
        line.ch    = ch;
        line.idx   = idx;
        line.typed = 1'b1;
        line.want  = '{entry: entry, row: row, col: col, scrolled: scr};
        directed_rows.push_back(line);
    endtask

    task automatic add_reg(input logic [1:0] sel, input logic [7:0] val);
        t_directed_row line;
        line = '0;
        line.kind    = ROW_REG;
        line.reg_sel = sel;
        line.reg_val = val;
        directed_rows.push_back(line);
    endtask

    // Result side: random stalls, compare each taken item with the oldest one queued
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got_result = '{entry: out_if.cell_entry, row: out_if.cursor_row,
                           col: out_if.cursor_col, scrolled: out_if.scrolled};
            if (pending_results.size() == 0) begin
                log_mismatch($sformatf("unexpected result entry=%h row=%0d col=%0d scr=%0b",
                                       got_result.entry, got_result.row,
                                       got_result.col, got_result.scrolled));
            end else begin
                head_result = pending_results.pop_front();
                if (got_result.entry !== head_result.entry ||
                    got_result.row !== head_result.row ||
                    got_result.col !== head_result.col ||
                    got_result.scrolled !== head_result.scrolled)
                    log_mismatch($sformatf({"expected entry=%h row=%0d col=%0d scr=%0b, ",
                                            "got entry=%h row=%0d col=%0d scr=%0b"},
                                           head_result.entry, head_result.row,
                                           head_result.col, head_result.scrolled,
                                           got_result.entry, got_result.row,
                                           got_result.col, got_result.scrolled));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int          p;
        int          k;
        int          pick;
        int          nl_pct;
        int          n_items;
        int unsigned cells;
        logic [7:0]  ph_cols;
        logic [5:0]  ph_rows;
        logic [11:0] ridx;

        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.opcode     <= tccs_pkg::OP_PUT;
        in_if.char_code  <= '0;
        in_if.cell_index <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        mismatch_count   = 0;
        n_put = 0; n_newline = 0; n_read = 0; n_scroll = 0; n_reg_writes = 0;

        for (k = 0; k < tccs_pkg::CellCount; k++) screen[k] = tccs_pkg::RESET_CELL;
        cur_row   = 0;
        cur_col   = 0;
        cfg_cols  = tccs_pkg::RESET_COLS;
        cfg_rows  = tccs_pkg::RESET_ROWS;
        cfg_color = tccs_pkg::RESET_COLOR;
        set_pacing(PACE_BOTH);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset contents, character extremes, newline at the default 80x25
        add_typed(tccs_pkg::OP_READ, 8'h00, 12'd0,    16'h0720, 5'd0, 7'd0, 1'b0);
        add_typed(tccs_pkg::OP_READ, 8'h00, 12'd4095, 16'h0720, 5'd0, 7'd0, 1'b0);
        add_typed(tccs_pkg::OP_PUT,  8'h41, 12'd0,    16'h0000, 5'd0, 7'd1, 1'b0);
        add_typed(tccs_pkg::OP_READ, 8'h00, 12'd0,    16'h0741, 5'd0, 7'd1, 1'b0);
        add_typed(tccs_pkg::OP_PUT,  8'h00, 12'hFFF,  16'h0000, 5'd0, 7'd2, 1'b0);
        add_typed(tccs_pkg::OP_PUT,  8'hFF, 12'd0,    16'h0000, 5'd0, 7'd3, 1'b0);
        add_typed(tccs_pkg::OP_PUT,  tccs_pkg::NEWLINE_CODE, 12'd0,
                  16'h0000, 5'd1, 7'd0, 1'b0);
        add_typed(tccs_pkg::OP_READ, 8'h00, 12'd1,    16'h0700, 5'd1, 7'd0, 1'b0);
        add_typed(tccs_pkg::OP_READ, 8'h00, 12'd2,    16'h07FF, 5'd1, 7'd0, 1'b0);
        // 4x2 screen: wrap on the last row scrolls, so does a newline there
        add_reg(tccs_pkg::REG_COLS, 8'd4);
        add_reg(tccs_pkg::REG_ROWS, 8'd2);
        add_item(tccs_pkg::OP_PUT, 8'h61, 12'd0);
        add_item(tccs_pkg::OP_PUT, 8'h62, 12'd0);
        add_item(tccs_pkg::OP_PUT, 8'h63, 12'd0);
        add_item(tccs_pkg::OP_PUT, 8'h64, 12'd0);
        add_item(tccs_pkg::OP_READ, 8'h00, 12'd0);
        add_item(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 12'd0);
        add_reg(tccs_pkg::REG_COLOR, 8'hFF);
        add_item(tccs_pkg::OP_PUT, 8'h78, 12'd0);
        add_item(tccs_pkg::OP_READ, 8'h00, 12'd4);
        // width and height below their minimum
        add_reg(tccs_pkg::REG_COLS, 8'd0);
        add_reg(tccs_pkg::REG_ROWS, 8'd1);
        add_reg(tccs_pkg::REG_COLOR, 8'h00);
        add_item(tccs_pkg::OP_PUT, 8'h79, 12'd0);
        add_item(tccs_pkg::OP_READ, 8'h00, 12'd0);
        // walk the cursor down, then shrink the screen under it
        add_reg(tccs_pkg::REG_COLS, 8'd8);
        add_reg(tccs_pkg::REG_ROWS, 8'd8);
        add_item(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 12'd0);
        add_item(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 12'd0);
        add_item(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 12'd0);
        add_item(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE, 12'd0);
        add_reg(tccs_pkg::REG_COLS, 8'd2);
        add_reg(tccs_pkg::REG_ROWS, 8'd3);
        add_item(tccs_pkg::OP_READ, 8'h00, 12'd0);
        add_item(tccs_pkg::OP_PUT, 8'h7A, 12'd0);
        // width and height above their maximum
        add_reg(tccs_pkg::REG_COLS, 8'd255);
        add_reg(tccs_pkg::REG_ROWS, 8'd63);
        add_item(tccs_pkg::OP_PUT, 8'h5A, 12'd0);
        add_item(tccs_pkg::OP_READ, 8'h00, 12'd4095);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG)
                reg_write(directed_rows[i].reg_sel, directed_rows[i].reg_val);
            else
                send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].idx,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases: each one drains, sets geometry and color, then runs
        for (p = 0; p < 12; p++) begin
            nl_pct  = 15;
            n_items = 40;
            case (p)
                0:       begin ph_cols = 8'd128; ph_rows = 6'd32; nl_pct = 60; end
                1:       begin ph_cols = 8'd1;   ph_rows = 6'd2;  end
                2:       begin ph_cols = 8'd255; ph_rows = 6'd63; nl_pct = 60; end
                3:       begin ph_cols = 8'd0;   ph_rows = 6'd0;  end
                4: begin
                    ph_cols = tccs_pkg::RESET_COLS;
                    ph_rows = tccs_pkg::RESET_ROWS;
                    nl_pct  = 30;
                end
                default: begin
                    ph_cols = 8'($urandom_range(8, 1));
                    ph_rows = 6'($urandom_range(5, 2));
                end
            endcase
            reg_write(tccs_pkg::REG_COLS, ph_cols);
            reg_write(tccs_pkg::REG_ROWS, {2'b00, ph_rows});
            reg_write(tccs_pkg::REG_COLOR, 8'($urandom_range(255)));
            set_pacing(t_pace'(p % 4));
            cells = eff_cols() * eff_rows();
            for (k = 0; k < n_items; k++) begin
                pick = $urandom_range(99);
                if (pick < nl_pct) begin
                    send_item(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE,
                              12'($urandom_range(4095)), 1'b0, '0);
                end else if (pick < nl_pct + 30) begin
                    // mostly cells on screen, some anywhere in the store
                    if ($urandom_range(9) < 7) ridx = 12'($urandom_range(cells - 1));
                    else ridx = 12'($urandom_range(4095));
                    send_item(tccs_pkg::OP_READ, 8'($urandom_range(255)), ridx, 1'b0, '0);
                end else begin
                    send_item(tccs_pkg::OP_PUT, 8'($urandom_range(255)),
                              12'($urandom_range(4095)), 1'b0, '0);
                end
            end
        end

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d puts, %0d newlines and %0d reads; %0d items scrolled the screen",
                 n_put, n_newline, n_read, n_scroll);
        $display("%0d register writes spanning below-minimum to above-maximum geometry",
                 n_reg_writes);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
